FILE: src/rtrs_pkg.sv
// Package for the trace rare-token scanner: descriptor and queue-entry types,
// stream bus widths and named codes shared by the front end, queue and back end.
// No dependencies.
package rtrs_pkg;

  // Request kinds on the input tuser bit.
  localparam logic REQ_TABLE = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  // Result kinds on the output tuser bit.
  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 88;
  localparam int SKIP_W      = 4;
  localparam int TOKEN_W     = 64;
  localparam int WIN_W       = 56;
  localparam int REC_CNT_W   = 16;

  // Queue between front and back end.
  localparam int Q_DEPTH = 4;
  localparam int QPW     = 2;
  localparam int QCW     = 3;

  typedef struct packed {
    logic [3:0] len;
    logic       rare;
    logic       ext;
    logic [3:0] rtype;
  } desc_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    desc_t      desc;
  } scan_item_t;

  typedef struct packed {
    logic           empty;
    logic [QCW-1:0] level;
  } q_stat_t;

endpackage

FILE: src/rtrs_front.sv
// Front end of the scanner: accepts input words, keeps the descriptor table
// memory and classifies each data byte by its descriptor. Depends on rtrs_pkg.
module rtrs_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [rtrs_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  input  rtrs_pkg::q_stat_t                 qs,
  output logic                              push,
  output rtrs_pkg::scan_item_t              push_item
);
  import rtrs_pkg::*;

  desc_t         mem [256];
  desc_t         rd_desc_r;
  logic          s1_valid_r;
  logic [7:0]    s1_byte_r;
  logic          s1_last_r;
  logic [QCW-1:0] occ;
  logic          acc;
  desc_t         wr_desc;
  logic [7:0]    t_index;
  logic [7:0]    d_byte;

  // The word held in stage one still counts against the queue room.
  assign occ       = qs.level + QCW'(s1_valid_r);
  assign in_tready = occ < QCW'(Q_DEPTH);
  assign acc       = in_tvalid && in_tready;

  assign t_index       = in_tdata[7:0];
  assign wr_desc.len   = in_tdata[11:8];
  assign wr_desc.rare  = in_tdata[12];
  assign wr_desc.ext   = in_tdata[13];
  assign wr_desc.rtype = in_tdata[17:14];
  assign d_byte        = in_tdata[25:18];

  always_ff @(posedge clk) begin
    if (acc && in_tuser == REQ_TABLE) begin
      mem[t_index] <= wr_desc;
    end
    if (acc && in_tuser == REQ_DATA) begin
      rd_desc_r <= mem[d_byte];
      s1_byte_r <= d_byte;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc && in_tuser == REQ_DATA;
    end
  end

  assign push           = s1_valid_r;
  assign push_item.data = s1_byte_r;
  assign push_item.last = s1_last_r;
  assign push_item.desc = rd_desc_r;

endmodule

FILE: src/rtrs_queue.sv
// Short queue of classified data bytes between front and back end.
// Depends on rtrs_pkg.
module rtrs_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rtrs_pkg::scan_item_t push_item,
  input  logic                 pop,
  output rtrs_pkg::scan_item_t head,
  output rtrs_pkg::q_stat_t    qs
);
  import rtrs_pkg::*;

  scan_item_t     ent_r [Q_DEPTH];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QCW-1:0] level_r;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      level_r <= level_r + QCW'(push) - QCW'(pop);
    end
  end

  assign head     = ent_r[rd_ptr_r];
  assign qs.empty = (level_r == '0);
  assign qs.level = level_r;

endmodule

FILE: src/rtrs_back.sv
// Back end of the scanner: token skip state, capture window, record cap,
// flush sequencer and the output register. Depends on rtrs_pkg.
module rtrs_back #(
  parameter int CAPTURE_BYTES   = 8,
  parameter int TOKEN_LEN_LIMIT = 9,
  parameter int COUNT_WIDTH     = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [15:0]                        cfg_data,
  input  rtrs_pkg::scan_item_t               head,
  input  rtrs_pkg::q_stat_t                  qs,
  output logic                               pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rtrs_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);
  import rtrs_pkg::*;

  localparam int TW = 4 * CAPTURE_BYTES;
  localparam int LW = (COUNT_WIDTH > REC_CNT_W) ? COUNT_WIDTH : REC_CNT_W;
  localparam logic [SKIP_W-1:0] MAX_LEN = SKIP_W'(TOKEN_LEN_LIMIT);

  logic [15:0]              max_rec_r;
  logic [SKIP_W-1:0]        skip_r,  skip_nxt;
  logic                     ext_r,   ext_nxt;
  logic [WIN_W-1:0]         win_r,   win_nxt;
  logic [CAPTURE_BYTES-1:0] mask_r,  mask_nxt;
  logic [TW-1:0]            types_r, types_nxt;
  logic [COUNT_WIDTH-1:0]   cnt_r,   cnt_nxt;

  logic                     fbusy_r, fbusy_nxt;
  logic [CAPTURE_BYTES-1:0] fmask_r, fmask_nxt;
  logic [TW-1:0]            ftypes_r, ftypes_nxt;
  logic [TOKEN_W-1:0]       fwin_r,  fwin_nxt;
  logic [COUNT_WIDTH-1:0]   fcnt_r,  fcnt_nxt;

  logic                     ov_r, ov_nxt;
  logic                     okind_r, okind_nxt;
  logic [TOKEN_W-1:0]       obytes_r, obytes_nxt;
  logic [3:0]               otype_r, otype_nxt;
  logic [REC_CNT_W-1:0]     ocnt_r, ocnt_nxt;
  logic                     olast_r, olast_nxt;

  logic                     can_emit;
  logic [TOKEN_W-1:0]       full;
  logic [CAPTURE_BYTES-1:0] mask_n;
  logic [TW-1:0]            types_n;
  logic [COUNT_WIDTH-1:0]   cnt_n;
  logic [SKIP_W-1:0]        lenv;
  logic                     cap_ok;
  logic [TOKEN_W-1:0]       sel_bytes;
  logic [3:0]               sel_type;
  logic [CAPTURE_BYTES-1:0] sel_oh;
  logic [LW-1:0]            fcnt_w;

  assign cfg_ready = 1'b1;
  assign can_emit  = !ov_r || out_tready;
  assign pop       = !qs.empty && !fbusy_r && can_emit;
  assign full      = {head.data, win_r};
  assign fcnt_w    = LW'(fcnt_r);

  // Per-byte token scan on the word at the queue head.
  always_comb begin
    mask_n   = CAPTURE_BYTES'(mask_r << 1);
    types_n  = TW'(types_r << 4);
    cnt_n    = cnt_r;
    skip_nxt = skip_r;
    ext_nxt  = ext_r;
    lenv     = head.desc.len;
    if (lenv == '0) begin
      lenv = SKIP_W'(1);
    end
    if (lenv > MAX_LEN) begin
      lenv = MAX_LEN;
    end
    cap_ok = (LW'(cnt_r) < LW'(max_rec_r)) && (cnt_r != '1);
    if (skip_r != '0) begin
      skip_nxt = skip_r - 1'b1;
    end else if (ext_r && head.data[0]) begin
      skip_nxt = skip_r;
    end else begin
      if (head.desc.rare && cap_ok) begin
        cnt_n      = cnt_r + 1'b1;
        mask_n[0]  = 1'b1;
        types_n[3:0] = head.desc.rtype;
      end
      ext_nxt  = head.desc.ext;
      skip_nxt = lenv - 1'b1;
    end
  end

  // Oldest pending capture in the flush snapshot.
  always_comb begin
    sel_bytes = '0;
    sel_type  = '0;
    sel_oh    = '0;
    for (int i = 0; i < CAPTURE_BYTES; i++) begin
      if (fmask_r[i]) begin
        sel_bytes = fwin_r >> (8 * (7 - i));
        sel_type  = ftypes_r[4*i +: 4];
        sel_oh    = '0;
        sel_oh[i] = 1'b1;
      end
    end
  end

  always_comb begin
    win_nxt    = win_r;
    mask_nxt   = mask_r;
    types_nxt  = types_r;
    cnt_nxt    = cnt_r;
    fbusy_nxt  = fbusy_r;
    fmask_nxt  = fmask_r;
    ftypes_nxt = ftypes_r;
    fwin_nxt   = fwin_r;
    fcnt_nxt   = fcnt_r;
    ov_nxt     = ov_r && !out_tready;
    okind_nxt  = okind_r;
    obytes_nxt = obytes_r;
    otype_nxt  = otype_r;
    ocnt_nxt   = ocnt_r;
    olast_nxt  = olast_r;

    if (fbusy_r && can_emit) begin
      ov_nxt = 1'b1;
      if (fmask_r != '0) begin
        okind_nxt  = KIND_RECORD;
        obytes_nxt = sel_bytes;
        otype_nxt  = sel_type;
        ocnt_nxt   = '0;
        olast_nxt  = 1'b0;
        fmask_nxt  = fmask_r & ~sel_oh;
      end else begin
        okind_nxt  = KIND_SUMMARY;
        obytes_nxt = '0;
        otype_nxt  = '0;
        ocnt_nxt   = fcnt_w[REC_CNT_W-1:0];
        olast_nxt  = 1'b1;
        fbusy_nxt  = 1'b0;
      end
    end else if (pop) begin
      if (head.last) begin
        // Snapshot everything pending and start the stream afresh.
        fbusy_nxt  = 1'b1;
        fmask_nxt  = mask_n;
        ftypes_nxt = types_n;
        fwin_nxt   = full;
        fcnt_nxt   = cnt_n;
        win_nxt    = '0;
        mask_nxt   = '0;
        types_nxt  = '0;
        cnt_nxt    = '0;
      end else begin
        win_nxt   = full[TOKEN_W-1:8];
        mask_nxt  = mask_n;
        types_nxt = types_n;
        cnt_nxt   = cnt_n;
        if (mask_n[CAPTURE_BYTES-1]) begin
          ov_nxt     = 1'b1;
          okind_nxt  = KIND_RECORD;
          obytes_nxt = full >> (8 * (8 - CAPTURE_BYTES));
          otype_nxt  = types_n[4*(CAPTURE_BYTES-1) +: 4];
          ocnt_nxt   = '0;
          olast_nxt  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_rec_r <= 16'hFFFF;
      skip_r    <= '0;
      ext_r     <= 1'b0;
      win_r     <= '0;
      mask_r    <= '0;
      types_r   <= '0;
      cnt_r     <= '0;
      fbusy_r   <= 1'b0;
      fmask_r   <= '0;
      ov_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        max_rec_r <= cfg_data;
      end
      if (pop) begin
        skip_r <= head.last ? '0 : skip_nxt;
        ext_r  <= head.last ? 1'b0 : ext_nxt;
      end
      win_r   <= win_nxt;
      mask_r  <= mask_nxt;
      types_r <= types_nxt;
      cnt_r   <= cnt_nxt;
      fbusy_r <= fbusy_nxt;
      fmask_r <= fmask_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ftypes_r <= ftypes_nxt;
    fwin_r   <= fwin_nxt;
    fcnt_r   <= fcnt_nxt;
    okind_r  <= okind_nxt;
    obytes_r <= obytes_nxt;
    otype_r  <= otype_nxt;
    ocnt_r   <= ocnt_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {4'b0, ocnt_r, otype_r, obytes_r};

endmodule

FILE: src/trace_rare_token_scanner_top.sv
// Top level of the trace rare-token scanner: front end, queue and back end.
// Depends on rtrs_pkg, rtrs_front, rtrs_queue and rtrs_back.
//
// Usage. The in_ stream carries two kinds of word, told apart by in_tuser:
// descriptor table writes (first-byte index, length, rare flag, extended flag
// and rare type) and trace stream bytes, whose in_tlast marks the final byte.
// The table must be written for every byte value that the stream will carry
// before that byte arrives. The out_ stream returns capture records (eight
// bytes from the token start, oldest byte lowest, with the rare type) and,
// after the final byte, one summary with the number of captures started;
// out_tlast marks the last result caused by an input word. The cfg_ channel
// writes the record cap and is always ready.
// Throughput is one word per cycle while in_tready is high. A record passes
// through the registered table read in the front end, the queue and the
// scan in the back end before it leaves the output register. At the final
// byte the back end snapshots its pending captures and emits one record for
// each of them and then the summary, during which the queue absorbs up to
// four further words. When the receiver stalls, the output register holds,
// the queue fills and in_tready falls. Reset clears the stream state and
// sets the cap to its maximum; the table is not cleared.
module trace_rare_token_scanner_top #(
  parameter int CAPTURE_BYTES   = 8,
  parameter int TOKEN_LEN_LIMIT = 9,
  parameter int COUNT_WIDTH     = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: table_index[7:0], table_length[11:8], table_rare[12],
  //        table_ext[13], table_rare_type[17:14], data_byte[25:18], zero pad
  input  logic [rtrs_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              in_tuser,   // req_type
  input  logic                              in_tlast,   // last_byte
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: token_bytes[63:0], token_type[67:64], record_count[83:68], zero pad
  output logic [rtrs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tuser,  // result_kind
  output logic                              out_tlast,  // last_of_run
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [15:0]                       cfg_data    // max_records
);
  import rtrs_pkg::*;

  logic       push;
  logic       pop;
  scan_item_t push_item;
  scan_item_t head;
  q_stat_t    qs;

  rtrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .qs        (qs),
    .push      (push),
    .push_item (push_item)
  );

  rtrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qs        (qs)
  );

  rtrs_back #(
    .CAPTURE_BYTES   (CAPTURE_BYTES),
    .TOKEN_LEN_LIMIT (TOKEN_LEN_LIMIT),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .head       (head),
    .qs         (qs),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: test/tb_trace_rare_token_scanner_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for trace_rare_token_scanner_top: a scoreboard class predicts
// capture records and stream summaries, and plain tasks drive the stream buses.
// Depends on rtrs_pkg and the scanner RTL.

class scan_scoreboard;
  localparam int CAP_BYTES = 8;
  localparam int LEN_MAX   = 9;

  typedef struct packed {
    logic        kind;
    logic [63:0] bytes;
    logic [3:0]  rtype;
    logic [15:0] count;
    logic        last;
  } scan_result_t;

  rtrs_pkg::desc_t desc_mem [256];
  logic [15:0]     cap;
  logic [3:0]      skip_left;
  logic            ext_mode;
  logic [55:0]     history;
  logic [7:0]      open_mask;
  logic [31:0]     open_types;
  logic [15:0]     started;
  scan_result_t    due_records [$];
  int n_err, n_records, n_summaries, n_table, n_bytes, n_capped;

  function new();
    cap = 16'hFFFF;
    clear_stream();
    n_err = 0;
    n_records = 0;
    n_summaries = 0;
    n_table = 0;
    n_bytes = 0;
    n_capped = 0;
  endfunction

  function void clear_stream();
    skip_left  = '0;
    ext_mode   = 1'b0;
    history    = '0;
    open_mask  = '0;
    open_types = '0;
    started    = '0;
  endfunction

  function int pending();
    return due_records.size();
  endfunction

  function void expect_result(logic kind, logic [63:0] bytes, logic [3:0] rtype,
                              logic [15:0] count, logic last);
    scan_result_t r;
    r.kind  = kind;
    r.bytes = bytes;
    r.rtype = rtype;
    r.count = count;
    r.last  = last;
    due_records.push_back(r);
  endfunction

  task report(string what);
    n_err++;
    if (n_err <= 100) $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Notes an accepted input word and queues the results that it causes.
  function void note_word(logic user, logic [31:0] tdata, logic last);
    rtrs_pkg::desc_t d;
    logic [7:0]  b;
    logic [63:0] full;
    int unsigned len;
    int          k;
    if (user == rtrs_pkg::REQ_TABLE) begin
      d.len   = tdata[11:8];
      d.rare  = tdata[12];
      d.ext   = tdata[13];
      d.rtype = tdata[17:14];
      desc_mem[tdata[7:0]] = d;
      n_table++;
      return;
    end
    n_bytes++;
    b          = tdata[25:18];
    full       = {b, history};
    history    = full[63:8];
    open_mask  = open_mask << 1;
    open_types = open_types << 4;
    if (skip_left != 0) begin
      skip_left = skip_left - 1'b1;
    end else if (ext_mode && b[0]) begin
      // Odd byte inside an extended token: skipped on its own.
    end else begin
      d   = desc_mem[b];
      len = 32'(d.len);
      if (len == 0) len = 1;
      if (len > LEN_MAX) len = LEN_MAX;
      if (d.rare && started < cap) begin
        started          = started + 1'b1;
        open_mask[0]     = 1'b1;
        open_types[3:0]  = d.rtype;
      end else if (d.rare) begin
        n_capped++;
      end
      ext_mode  = d.ext;
      skip_left = 4'(len - 1);
    end
    if (open_mask[CAP_BYTES-1]) begin
      expect_result(rtrs_pkg::KIND_RECORD, full, open_types[31:28], '0, !last);
      open_mask[CAP_BYTES-1] = 1'b0;
    end
    if (last) begin
      for (k = CAP_BYTES - 1; k >= 0; k--) begin
        if (open_mask[k])
          expect_result(rtrs_pkg::KIND_RECORD, full >> (8 * (7 - k)),
                        open_types[4*k +: 4], '0, 1'b0);
      end
      expect_result(rtrs_pkg::KIND_SUMMARY, '0, '0, started, 1'b1);
      clear_stream();
    end
  endfunction

  // Compares one accepted result word with the oldest expectation.
  task check_result(logic user, logic [rtrs_pkg::OUT_TDATA_W-1:0] tdata, logic last);
    scan_result_t want;
    if (due_records.size() == 0) begin
      report($sformatf("result with nothing expected: kind %0d tdata %h", user, tdata));
      return;
    end
    want = due_records.pop_front();
    if (user !== want.kind)
      report($sformatf("result kind %0d, expected %0d", user, want.kind));
    if (tdata[63:0] !== want.bytes)
      report($sformatf("token bytes %h, expected %h", tdata[63:0], want.bytes));
    if (tdata[67:64] !== want.rtype)
      report($sformatf("token type %0d, expected %0d", tdata[67:64], want.rtype));
    if (tdata[83:68] !== want.count)
      report($sformatf("record count %0d, expected %0d", tdata[83:68], want.count));
    if (last !== want.last)
      report($sformatf("tlast %0d, expected %0d", last, want.last));
    if (want.kind == rtrs_pkg::KIND_RECORD) n_records++;
    else n_summaries++;
  endtask
endclass

module tb_trace_rare_token_scanner_top;
  import rtrs_pkg::*;

  // The receiver's long hold, the settling time before a register write (pipeline,
  // queue and flush of a full set of pending captures) and the end-of-run wait.
  localparam int HOLD_CYCLES   = 90;
  localparam int SETTLE_CYCLES = 24;
  localparam int TAIL_CYCLES   = 40;
  localparam int PHASE_WORDS   = 30;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [15:0]            cfg_data;

  scan_scoreboard sb;

  // Run flags and counters; calm and hold_req are shared by sender and receiver. calm
  // switches off all idling in the last part of the run; hold_req asks the receiver for one long stall.
  bit calm     = 1'b0;
  bit src_gaps = 1'b0;
  bit hold_req = 1'b0;
  int n_holds  = 0;
  int n_streams = 0;
  int n_cap_writes = 0;

  trace_rare_token_scanner_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Offers one word and waits for its handshake. in_tvalid is only lowered at the start
  // of an idle burst, so back-to-back words keep it high without a glitch. Handshake
  // signals are read straight after the edge, which gives the values the block saw.
  task automatic send_word(input logic user, input logic [IN_TDATA_W-1:0] data,
                           input logic last);
    if (!calm && src_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= user;
    in_tdata  <= data;
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_word(user, data, last);
  endtask

  // Descriptor write. The data byte field is filled at random, as the block ignores it.
  task automatic send_table(input logic [7:0] idx, input logic [3:0] len, input logic rare,
                            input logic ext, input logic [3:0] rtype, input logic last);
    logic [7:0] junk;
    junk = 8'($urandom);
    send_word(REQ_TABLE, {6'b0, junk, rtype, ext, rare, len, idx}, last);
  endtask

  // Stream byte. The descriptor fields carry random junk.
  task automatic send_byte(input logic [7:0] b, input logic last);
    logic [17:0] junk;
    junk = 18'($urandom);
    send_word(REQ_DATA, {6'b0, b, junk}, last);
  endtask

  task automatic send_random_table();
    send_table(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endtask

  // Stops offering words until every expected result has come back, then lets the
  // block drain words that cause no result before anything is reconfigured.
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cap(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.cap = value;
    n_cap_writes++;
  endtask

  // Random streams of random bytes, each closed by a final byte, with the odd table
  // rewrite in between. Optionally asks for the long receiver hold, or pauses the
  // sender until all results are in, once the given number of words has gone.
  task automatic run_phase(input int budget, input int hold_at, input int pause_at);
    int sent;
    int len;
    int j;
    bit held;
    bit paused;
    sent = 0;
    held = 1'b0;
    paused = 1'b0;
    while (sent < budget) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 20);
      src_gaps = ($urandom_range(0, 3) != 0);
      for (j = 0; j < len; j++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_random_table();
          sent++;
        end
        send_byte(8'($urandom_range(0, 255)), j == len - 1);
        sent++;
        if (!held && hold_at >= 0 && sent >= hold_at) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        if (!paused && pause_at >= 0 && sent >= pause_at) begin
          in_tvalid <= 1'b0;
          do @(posedge clk); while (sb.pending() != 0);
          paused = 1'b1;
        end
      end
      n_streams++;
    end
  endtask

  // Receiver. Checks every accepted result and alternates runs of readiness with
  // stall bursts; a hold request from the sender side gives one long stall that
  // fills the queue and pushes back on the input.
  initial begin : result_sink
    int stall_left;
    int free_left;
    stall_left = 0;
    free_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1)
        sb.check_result(out_tuser, out_tdata, out_tlast);
      if (stall_left > 0) begin
        stall_left--;
      end else if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
        n_holds++;
      end else if (free_left > 0) begin
        free_left--;
      end else if (!calm && $urandom_range(0, 1) == 0) begin
        stall_left = $urandom_range(1, 13);
      end else begin
        free_left = $urandom_range(1, 40);
      end
      out_tready <= (stall_left == 0);
    end
  end

  initial begin : stimulus
    int i;
    int p;
    int guard;
    logic [15:0] cap;
    logic [3:0]  len;
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= REQ_TABLE;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // The table is not cleared by reset, so every entry is written before any byte
    // is scanned. Short lengths dominate so that tokens start often.
    write_cap(16'hFFFF);
    src_gaps = 1'b1;
    for (i = 0; i < 256; i++) begin
      case ($urandom_range(0, 9))
        0:       len = 4'($urandom_range(10, 15));
        1, 2, 3: len = 4'($urandom_range(3, 9));
        default: len = 4'($urandom_range(0, 2));
      endcase
      send_table(8'(i), len, $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0,
                 4'($urandom_range(0, 15)), 1'b0);
    end

    // Directed part. 0xFF starts an extended rare token whose overlong length is cut to
    // nine bytes; after it, odd bytes are skipped singly until the even 0x42 starts a
    // rare token, which is flushed zero padded at the final byte. A table write with
    // tlast set in mid-stream must neither end the stream nor produce anything.
    send_table(8'hFF, 4'd15, 1'b1, 1'b1, 4'd15, 1'b0);
    send_table(8'h00, 4'd0, 1'b0, 1'b0, 4'd0, 1'b0);
    send_table(8'h42, 4'd1, 1'b1, 1'b0, 4'd9, 1'b0);
    send_byte(8'hFF, 1'b0);
    for (i = 0; i < 8; i++) send_byte(8'h00, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h42, 1'b0);
    send_table(8'h03, 4'd2, 1'b1, 1'b0, 4'd3, 1'b1);
    send_byte(8'h00, 1'b1);
    // A stream of a single rare byte: one padded record, then its summary.
    send_byte(8'h42, 1'b1);
    n_streams += 2;
    // A cap of zero captures nothing; a cap of one stops after the first capture.
    settle_idle();
    write_cap(16'd0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h42, 1'b1);
    settle_idle();
    write_cap(16'd1);
    send_byte(8'h42, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h42, 1'b1);
    n_streams += 2;

    // Random phases, each under its own record cap. The first phase is long and
    // carries the long receiver hold, the middle ones run a single stream each with
    // a sender pause in the third, and the last phase runs without any idling.
    for (p = 0; p < 6; p++) begin
      case (p)
        0:       cap = 16'hFFFF;
        1:       cap = 16'd2;
        2:       cap = 16'd0;
        3:       cap = 16'($urandom_range(3, 12));
        4:       cap = 16'd1;
        default: cap = 16'hFFFF;
      endcase
      settle_idle();
      calm = (p == 5);
      write_cap(cap);
      run_phase((p == 0) ? PHASE_WORDS : ((p == 5) ? 12 : 1), (p == 0) ? 4 : -1,
                (p == 2) ? 1 : -1);
    end
    in_tvalid <= 1'b0;

    guard = 0;
    while (sb.pending() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));

    $display("Run covered %0d table writes and %0d stream bytes in %0d streams, %0d cap writes.",
             sb.n_table, sb.n_bytes, n_streams, n_cap_writes);
    $display("Checked %0d capture records and %0d summaries; %0d rare tokens beyond the cap.",
             sb.n_records, sb.n_summaries, sb.n_capped);
    if (sb.n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Generous upper bound on the run; a hang ends here as a failure.
  initial begin : watchdog
    #5_000_000;
    $display("Timeout: the run did not finish in time.");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
src/rtrs_pkg.sv
src/rtrs_front.sv
src/rtrs_queue.sv
src/rtrs_back.sv
src/trace_rare_token_scanner_top.sv
test/tb_trace_rare_token_scanner_top.sv
